// ===== rtl/core/wpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted pose fusion package
// Shared types, register codes, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package wpf_pkg;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam int          APB_AW       = 4;
    localparam logic [1:0]  REG_START_X  = 2'd0;
    localparam logic [1:0]  REG_START_Y  = 2'd1;
    localparam logic [1:0]  REG_START_H  = 2'd2;
    localparam logic [1:0]  REG_PERIOD   = 2'd3;

    // Q16.16 angle constants.
    localparam logic signed [31:0] PI_Q       = 32'sd205887;
    localparam logic signed [31:0] TWO_PI_Q   = 32'sd411775;
    localparam logic signed [32:0] THREE_Q_PI = 33'sd154415;

    localparam logic [4:0]  WARMUP_TICKS = 5'd20;
    localparam int          LANES        = 3;
    localparam int          LANE_H       = 2;

    // ceil(2^24 / 5); exact quotient by five for any 21-bit operand.
    localparam logic [42:0] DIV5_MUL     = 43'd3355444;

    localparam logic signed [31:0] START_X_RST = 32'sd215613;
    localparam logic signed [31:0] START_Y_RST = 32'sd504627;
    localparam logic signed [18:0] START_H_RST = -19'sd102957;
    localparam logic [7:0]         PERIOD_RST  = 8'd20;

    typedef struct packed {
        logic               odo_new;
        logic signed [31:0] odo_x;
        logic signed [31:0] odo_y;
        logic signed [31:0] odo_heading;
        logic               cam_new;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_heading;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_heading;
        logic               fused;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] h;
    } pose3_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [18:0] start_heading;
        logic [7:0]         output_period;
    } cfg_t;

    typedef struct packed {
        logic load_start;
        logic period_wr;
    } cfg_evt_t;

    typedef struct packed {
        logic   fused;
        pose3_t a;
        pose3_t b;
    } fuse_req_t;

    localparam cfg_t CFG_RST = '{
        start_x:       START_X_RST,
        start_y:       START_Y_RST,
        start_heading: START_H_RST,
        output_period: PERIOD_RST
    };

    localparam pose3_t START_POSE_RST = '{
        x: START_X_RST,
        y: START_Y_RST,
        h: 32'(START_H_RST)
    };

    // One correction toward the +-pi band.
    function automatic logic signed [31:0] wrap_once(input logic signed [31:0] h);
        logic signed [31:0] r;
        if (h > PI_Q) begin
            r = h - TWO_PI_Q;
        end
        else if (h < -PI_Q) begin
            r = h + TWO_PI_Q;
        end
        else begin
            r = h;
        end
        return r;
    endfunction

    // Quotient by five through a reciprocal multiply.
    function automatic logic [18:0] div5(input logic [20:0] x);
        logic [42:0] p;
        p = 43'(x) * DIV5_MUL;
        return p[42:24];
    endfunction

endpackage

// ===== rtl/core/weighted_pose_fusion.sv =====
`timescale 1ns / 1ps
// A result passes the request, sum, quotient and output registers after its tick is transferred.
// Throughput: one tick per cycle unless the output stalls or a period rebuild runs.
// A write to output_period holds tick_ready low while the idle
// counter remainder is rebuilt one bit per cycle.
// Reset (rst_n low, asynchronous) loads the default start pose, period 20,
// empties the pipeline and starts the 20-tick warm-up.
// ----------------------------------------------------------------------------
// Weighted pose fusion
// Fuses odometry with occasional ceiling-camera poses by a 19:1 weighted
// average with heading unwrapping, and passes odometry through when idle.
// ----------------------------------------------------------------------------
module weighted_pose_fusion (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick_valid,
    output logic                        tick_ready,
    input  wpf_pkg::tick_t              tick,
    output logic                        pose_valid,
    input  logic                        pose_ready,
    output wpf_pkg::pose_t              pose,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    wpf_pkg::cfg_t       cfg, cfg_next;
    wpf_pkg::cfg_evt_t   evt;
    wpf_pkg::fuse_req_t  req;
    logic                fire, emit, trk_busy, pipe_ready;

    assign tick_ready = pipe_ready && !trk_busy;
    assign fire       = tick_valid && tick_ready;

    wpf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .cfg_next (cfg_next),
        .evt      (evt)
    );

    wpf_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_next (cfg_next),
        .evt      (evt),
        .tick     (tick),
        .fire     (fire),
        .busy     (trk_busy),
        .emit     (emit),
        .req      (req)
    );

    wpf_blend_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (fire && emit),
        .req        (req),
        .req_ready  (pipe_ready),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose)
    );

`ifndef SYNTHESIS
    // A period write must pause tick transfers while the remainder is rebuilt.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[3:2] == wpf_pkg::REG_PERIOD))
        |=> !tick_ready)
    else $error("tick_ready high right after an output_period write");

    // Outside the rebuild, ticks are refused only when the pipeline is full
    // and the result at the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!tick_ready && !trk_busy) |-> (pose_valid && !pose_ready))
    else $error("tick_ready low without a stalled result");
`endif

endmodule

// ===== rtl/core/wpf_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the start pose and the idle output period.
// ----------------------------------------------------------------------------
module wpf_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output wpf_pkg::cfg_t               cfg,
    output wpf_pkg::cfg_t               cfg_next,
    output wpf_pkg::cfg_evt_t           evt
);

    wpf_pkg::cfg_t cfg_reg;
    logic          wr;
    logic [1:0]    idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        evt      = '0;
        if (wr)
        begin
            unique case (idx)
                wpf_pkg::REG_START_X:
                begin
                    cfg_next.start_x = signed'(pwdata);
                    evt.load_start   = 1'b1;
                end
                wpf_pkg::REG_START_Y:
                begin
                    cfg_next.start_y = signed'(pwdata);
                    evt.load_start   = 1'b1;
                end
                wpf_pkg::REG_START_H:
                begin
                    cfg_next.start_heading = signed'(pwdata[18:0]);
                    evt.load_start         = 1'b1;
                end
                wpf_pkg::REG_PERIOD:
                begin
                    cfg_next.output_period = pwdata[7:0];
                    evt.period_wr          = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            wpf_pkg::REG_START_X: prdata = cfg_reg.start_x;
            wpf_pkg::REG_START_Y: prdata = cfg_reg.start_y;
            wpf_pkg::REG_START_H: prdata = {13'd0, cfg_reg.start_heading};
            wpf_pkg::REG_PERIOD:  prdata = {24'd0, cfg_reg.output_period};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= wpf_pkg::CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/wpf_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose tracker
// Holds the latest odometry and camera poses, the warm-up and idle counters,
// and decides per tick whether a result is produced and what goes into it.
// ----------------------------------------------------------------------------
module wpf_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wpf_pkg::cfg_t         cfg,
    input  wpf_pkg::cfg_t         cfg_next,
    input  wpf_pkg::cfg_evt_t     evt,
    input  wpf_pkg::tick_t        tick,
    input  logic                  fire,
    output logic                  busy,
    output logic                  emit,
    output wpf_pkg::fuse_req_t    req
);

    wpf_pkg::pose3_t    odo_reg, odo_next, cam_reg, cam_next;
    wpf_pkg::pose3_t    start_pose, load_pose, odo_in, cam_in;
    logic [4:0]         warm_reg, warm_next;
    logic [7:0]         idle_reg, idle_next, rem_reg, rem_next, period_eff;
    logic               busy_reg, busy_next;
    logic [2:0]         step_reg, step_next;
    logic               warm, hit, wrap_edit;
    logic [8:0]         rem_inc, rem_shift;
    logic signed [32:0] cam_h_ext, cam_h_mag;
    logic signed [31:0] oh, ch;

    assign busy = busy_reg;

    always_comb
    begin
        start_pose.x = cfg.start_x;
        start_pose.y = cfg.start_y;
        start_pose.h = {{13{cfg.start_heading[18]}}, cfg.start_heading};
        load_pose.x  = cfg_next.start_x;
        load_pose.y  = cfg_next.start_y;
        load_pose.h  = {{13{cfg_next.start_heading[18]}}, cfg_next.start_heading};

        odo_in = odo_reg;
        if (tick.odo_new)
        begin
            odo_in.x = tick.odo_x;
            odo_in.y = tick.odo_y;
            odo_in.h = tick.odo_heading;
        end
        cam_in.x = tick.cam_x;
        cam_in.y = tick.cam_y;
        cam_in.h = tick.cam_heading;

        // Headings on opposite sides near +-pi: lift the negative one by 2pi
        // so the average does not land near zero. The edit is kept.
        oh        = odo_in.h;
        ch        = cam_in.h;
        cam_h_ext = 33'(ch);
        cam_h_mag = cam_h_ext[32] ? -cam_h_ext : cam_h_ext;
        wrap_edit = tick.cam_new && ((oh < 0 && ch > 0) || (oh > 0 && ch < 0))
                    && (cam_h_mag > wpf_pkg::THREE_Q_PI);
        if (wrap_edit)
        begin
            if (oh > ch)
            begin
                cam_in.h = ch + wpf_pkg::TWO_PI_Q;
            end
            else
            begin
                odo_in.h = oh + wpf_pkg::TWO_PI_Q;
            end
        end

        warm       = warm_reg < wpf_pkg::WARMUP_TICKS;
        period_eff = (cfg.output_period == 8'd0) ? 8'd1 : cfg.output_period;
        rem_inc    = 9'(rem_reg) + 9'd1;
        hit        = (idle_reg == 8'hFF) || (rem_inc == {1'b0, period_eff});

        req.b = cam_in;
        if (warm)
        begin
            emit      = 1'b1;
            req.fused = 1'b0;
            req.a     = start_pose;
        end
        else if (tick.cam_new)
        begin
            emit      = 1'b1;
            req.fused = 1'b1;
            req.a     = odo_in;
        end
        else
        begin
            emit      = hit;
            req.fused = 1'b0;
            req.a.x   = odo_in.x;
            req.a.y   = odo_in.y;
            req.a.h   = wpf_pkg::wrap_once(odo_in.h);
        end
    end

    // Next state. rem_reg tracks idle_reg modulo the period; after a period
    // write it is rebuilt one bit per cycle by restoring division.
    always_comb
    begin
        odo_next  = odo_reg;
        cam_next  = cam_reg;
        warm_next = warm_reg;
        idle_next = idle_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        rem_shift = {rem_reg, idle_reg[3'd7 - step_reg]};

        if (busy_reg)
        begin
            if (rem_shift >= {1'b0, period_eff})
            begin
                rem_shift = rem_shift - {1'b0, period_eff};
            end
            rem_next  = rem_shift[7:0];
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end

        if (fire)
        begin
            if (warm)
            begin
                warm_next = warm_reg + 5'd1;
            end
            else
            begin
                odo_next = odo_in;
                if (tick.cam_new)
                begin
                    cam_next  = cam_in;
                    idle_next = 8'd0;
                    rem_next  = 8'd0;
                end
                else if (hit)
                begin
                    idle_next = 8'd0;
                    rem_next  = 8'd0;
                end
                else
                begin
                    idle_next = idle_reg + 8'd1;
                    rem_next  = rem_inc[7:0];
                end
            end
        end

        if (evt.load_start)
        begin
            odo_next  = load_pose;
            cam_next  = load_pose;
            warm_next = 5'd0;
        end

        if (evt.period_wr)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            rem_next  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odo_reg  <= wpf_pkg::START_POSE_RST;
            cam_reg  <= wpf_pkg::START_POSE_RST;
            warm_reg <= 5'd0;
            idle_reg <= 8'd0;
            rem_reg  <= 8'd0;
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            odo_reg  <= odo_next;
            cam_reg  <= cam_next;
            warm_reg <= warm_next;
            idle_reg <= idle_next;
            rem_reg  <= rem_next;
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/core/wpf_blend_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blend pipeline
// Four-stage pipeline computing (19a + b) / 20 truncated toward zero on each
// lane, the heading wrap, and the output register.
// ----------------------------------------------------------------------------
module wpf_blend_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  wpf_pkg::fuse_req_t    req,
    output logic                  req_ready,
    output logic                  pose_valid,
    input  logic                  pose_ready,
    output wpf_pkg::pose_t        pose
);

    localparam int L = wpf_pkg::LANES;

    // Stage 1: request as taken.
    logic                 v1_reg;
    wpf_pkg::fuse_req_t   r1_reg;
    logic signed [31:0]   a1[L];
    logic signed [31:0]   b1[L];

    // Stage 2: magnitude of the weighted sum divided by four.
    logic                 v2_reg, f2_reg;
    logic signed [31:0]   a2_reg[L];
    logic [33:0]          m2_reg[L], m2_next[L];
    logic                 n2_reg[L], n2_next[L];
    logic signed [37:0]   sum2[L];
    logic [37:0]          mag2[L];

    // Stage 3: high part divided by five, remainder folded into the low part.
    logic                 v3_reg, f3_reg;
    logic signed [31:0]   a3_reg[L];
    logic [13:0]          qh3_reg[L], qh3_next[L];
    logic [20:0]          lo3_reg[L], lo3_next[L];
    logic                 n3_reg[L];
    logic [18:0]          qh_full[L];
    logic [16:0]          rh_t[L];

    // Stage 4: output register.
    logic                 v4_reg;
    wpf_pkg::pose_t       pose_reg, pose_next;
    logic [18:0]          ql[L];
    logic [32:0]          q33[L], qs[L];
    logic signed [31:0]   bl[L];

    logic                 en1, en2, en3, en4;

    assign en4        = !v4_reg || pose_ready;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign req_ready  = en1;
    assign pose_valid = v4_reg;
    assign pose       = pose_reg;

    always_comb
    begin
        a1[0] = r1_reg.a.x;
        a1[1] = r1_reg.a.y;
        a1[2] = r1_reg.a.h;
        b1[0] = r1_reg.b.x;
        b1[1] = r1_reg.b.y;
        b1[2] = r1_reg.b.h;
        for (int i = 0; i < L; i++)
        begin
            sum2[i]    = (38'(a1[i]) <<< 4) + (38'(a1[i]) <<< 1) + 38'(a1[i])
                         + 38'(b1[i]);
            mag2[i]    = sum2[i][37] ? 38'(-sum2[i]) : 38'(sum2[i]);
            m2_next[i] = mag2[i][35:2];
            n2_next[i] = sum2[i][37];
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            qh_full[i]  = wpf_pkg::div5({5'd0, m2_reg[i][33:18]});
            qh3_next[i] = qh_full[i][13:0];
            rh_t[i]     = 17'(m2_reg[i][33:18])
                          - ((17'(qh_full[i][13:0]) << 2) + 17'(qh_full[i][13:0]));
            lo3_next[i] = {rh_t[i][2:0], m2_reg[i][17:0]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            ql[i]  = wpf_pkg::div5(lo3_reg[i]);
            q33[i] = {1'b0, qh3_reg[i], 18'd0} + {14'd0, ql[i]};
            qs[i]  = n3_reg[i] ? (33'd0 - q33[i]) : q33[i];
            bl[i]  = signed'(qs[i][31:0]);
        end
        pose_next.fused = f3_reg;
        if (f3_reg)
        begin
            pose_next.pose_x       = bl[0];
            pose_next.pose_y       = bl[1];
            pose_next.pose_heading = wpf_pkg::wrap_once(bl[wpf_pkg::LANE_H]);
        end
        else
        begin
            pose_next.pose_x       = a3_reg[0];
            pose_next.pose_y       = a3_reg[1];
            pose_next.pose_heading = a3_reg[wpf_pkg::LANE_H];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && req_valid)
        begin
            r1_reg <= req;
        end
        if (en2 && v1_reg)
        begin
            f2_reg <= r1_reg.fused;
            for (int i = 0; i < L; i++)
            begin
                a2_reg[i] <= a1[i];
                m2_reg[i] <= m2_next[i];
                n2_reg[i] <= n2_next[i];
            end
        end
        if (en3 && v2_reg)
        begin
            f3_reg <= f2_reg;
            for (int i = 0; i < L; i++)
            begin
                a3_reg[i]  <= a2_reg[i];
                qh3_reg[i] <= qh3_next[i];
                lo3_reg[i] <= lo3_next[i];
                n3_reg[i]  <= n2_reg[i];
            end
        end
        if (en4 && v3_reg)
        begin
            pose_reg <= pose_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted pose fusion testbench
// Sends tick items through the valid/ready input and predicts each emitted
// pose from a shadow copy of the fusion state. The checker compares every
// pose transfer with the oldest prediction. Both sides pause at random.
// Directed cases cover warm-up, the heading seam near +-pi, the wrap of odometry
// headings, output period extremes and the idle counter rolling over. Start
// pose and period settings are swept over the configuration port before the
// random phases run.
// ----------------------------------------------------------------------------
module tb;

    localparam int     CLK_HALF      = 5;
    localparam int     STALL_LIMIT   = 1000;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     MAX_REPORTS   = 40;
    localparam int     WARMUP_LEN    = 20;
    localparam int     RANDOM_ITEMS  = 20;
    localparam longint ANG_PI        = 205887;
    localparam longint ANG_2PI       = 411775;
    localparam longint ANG_3Q        = 154415;
    localparam int     S32_MAX       = 32'sh7FFF_FFFF;
    localparam int     S32_MIN       = 32'sh8000_0000;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         tick_valid = 1'b0;
    logic                         tick_ready;
    wpf_pkg::tick_t               tick       = '0;
    logic                         pose_valid;
    logic                         pose_ready = 1'b0;
    wpf_pkg::pose_t               pose;
    logic                         psel       = 1'b0;
    logic                         penable    = 1'b0;
    logic                         pwrite     = 1'b0;
    logic [wpf_pkg::APB_AW-1:0]   paddr      = '0;
    logic [31:0]                  pwdata     = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    // Shadow of the block's configuration and fusion state.
    wpf_pkg::cfg_t   cfg_shadow = '{start_x: 215613, start_y: 504627,
                                    start_heading: -19'sd102957, output_period: 8'd20};
    wpf_pkg::pose3_t odo_pose;
    wpf_pkg::pose3_t cam_pose;
    wpf_pkg::pose3_t emit_pose;
    int              warm_ticks;
    logic [7:0]      idle_run;
    wpf_pkg::pose_t  expected_poses[$];

    int          error_count = 0;
    int          fused_seen  = 0;
    int          passed_seen = 0;
    int          unwrap_hits = 0;
    int          ticks_sent  = 0;
    bit          no_gaps     = 1'b0;

    weighted_pose_fusion u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
        begin
            $display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // 19:1 weighted average, exact in 64 bits, truncated toward zero.
    function automatic logic signed [31:0] blend_19_1(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        longint sum;
        sum = 19 * longint'(a) + longint'(b);
        return 32'(sum / 20);
    endfunction

    function automatic logic signed [31:0] fold_heading(input logic signed [31:0] h);
        longint v;
        v = longint'(h);
        if (v > ANG_PI)
        begin
            v = v - ANG_2PI;
        end
        else if (v < -ANG_PI)
        begin
            v = v + ANG_2PI;
        end
        return 32'(v);
    endfunction

    task automatic reload_start_pose();
        wpf_pkg::pose3_t p;
        p.x = cfg_shadow.start_x;
        p.y = cfg_shadow.start_y;
        p.h = {{13{cfg_shadow.start_heading[18]}}, cfg_shadow.start_heading};
        odo_pose   = p;
        cam_pose   = p;
        emit_pose  = p;
        warm_ticks = 0;
    endtask

    task automatic queue_pose(input logic fused);
        wpf_pkg::pose_t r;
        r.pose_x       = emit_pose.x;
        r.pose_y       = emit_pose.y;
        r.pose_heading = emit_pose.h;
        r.fused        = fused;
        expected_poses.push_back(r);
    endtask

    task automatic predict_tick(input wpf_pkg::tick_t t);
        longint oh;
        longint ch;
        longint mag;
        int     period;
        if (warm_ticks < WARMUP_LEN)
        begin
            warm_ticks++;
            queue_pose(1'b0);
        end
        else
        begin
            if (t.odo_new)
            begin
                odo_pose.x = t.odo_x;
                odo_pose.y = t.odo_y;
                odo_pose.h = t.odo_heading;
            end
            if (t.cam_new)
            begin
                cam_pose.x  = t.cam_x;
                cam_pose.y  = t.cam_y;
                cam_pose.h  = t.cam_heading;
                emit_pose.x = blend_19_1(odo_pose.x, cam_pose.x);
                emit_pose.y = blend_19_1(odo_pose.y, cam_pose.y);
                oh  = longint'(odo_pose.h);
                ch  = longint'(cam_pose.h);
                mag = (ch < 0) ? -ch : ch;
                // Headings on opposite sides of the seam: lift the negative one by
                // a full turn, and keep the edit in the stored pose.
                if (((oh < 0 && ch > 0) || (oh > 0 && ch < 0)) && mag > ANG_3Q)
                begin
                    unwrap_hits++;
                    if (oh > ch)
                    begin
                        cam_pose.h = 32'(ch + ANG_2PI);
                    end
                    else
                    begin
                        odo_pose.h = 32'(oh + ANG_2PI);
                    end
                end
                emit_pose.h = fold_heading(blend_19_1(odo_pose.h, cam_pose.h));
                idle_run    = 8'd0;
                queue_pose(1'b1);
            end
            else
            begin
                emit_pose.x = odo_pose.x;
                emit_pose.y = odo_pose.y;
                emit_pose.h = fold_heading(odo_pose.h);
                period      = (cfg_shadow.output_period == 8'd0) ? 1 : cfg_shadow.output_period;
                idle_run    = idle_run + 8'd1;
                if (int'(idle_run) % period == 0)
                begin
                    idle_run = 8'd0;
                    queue_pose(1'b0);
                end
            end
        end
    endtask

    task automatic check_pose(input wpf_pkg::pose_t got);
        wpf_pkg::pose_t want;
        if (expected_poses.size() == 0)
        begin
            report_mismatch("pose with no tick pending", got.pose_x, 32'd0);
        end
        else
        begin
            want = expected_poses.pop_front();
            if (got.pose_x !== want.pose_x)
            begin
                report_mismatch("pose_x", got.pose_x, want.pose_x);
            end
            if (got.pose_y !== want.pose_y)
            begin
                report_mismatch("pose_y", got.pose_y, want.pose_y);
            end
            if (got.pose_heading !== want.pose_heading)
            begin
                report_mismatch("pose_heading", got.pose_heading, want.pose_heading);
            end
            if (got.fused !== want.fused)
            begin
                report_mismatch("fused", 32'(got.fused), 32'(want.fused));
            end
            if (want.fused)
            begin
                fused_seen++;
            end
            else
            begin
                passed_seen++;
            end
        end
    endtask

    task automatic send_tick(input wpf_pkg::tick_t t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick       <= t;
        tick_valid <= 1'b1;
        do @(posedge clk); while (!tick_ready);
        predict_tick(t);
        ticks_sent++;
    endtask

    // Lets every expected pose drain and the pipeline empty before a register write.
    task automatic settle();
        tick_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_readback(input logic [1:0] idx);
        logic [31:0] mask;
        logic [31:0] want;
        case (idx)
            wpf_pkg::REG_START_X:
            begin
                want = cfg_shadow.start_x;
                mask = 32'hFFFF_FFFF;
            end
            wpf_pkg::REG_START_Y:
            begin
                want = cfg_shadow.start_y;
                mask = 32'hFFFF_FFFF;
            end
            wpf_pkg::REG_START_H:
            begin
                want = {13'd0, cfg_shadow.start_heading};
                mask = 32'h0007_FFFF;
            end
            default:
            begin
                want = {24'd0, cfg_shadow.output_period};
                mask = 32'h0000_00FF;
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (want & mask))
        begin
            report_mismatch("register readback", prdata & mask, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            wpf_pkg::REG_START_X:
            begin
                cfg_shadow.start_x = data;
                reload_start_pose();
            end
            wpf_pkg::REG_START_Y:
            begin
                cfg_shadow.start_y = data;
                reload_start_pose();
            end
            wpf_pkg::REG_START_H:
            begin
                cfg_shadow.start_heading = data[18:0];
                reload_start_pose();
            end
            default:
            begin
                cfg_shadow.output_period = data[7:0];
            end
        endcase
        @(posedge clk);
        reg_readback(idx);
    endtask

    function automatic wpf_pkg::tick_t make_tick(input bit on, input int ox, input int oy,
                                                 input int oh, input bit cn, input int cx,
                                                 input int cy, input int ch);
        wpf_pkg::tick_t t;
        t.odo_new     = on;
        t.odo_x       = ox;
        t.odo_y       = oy;
        t.odo_heading = oh;
        t.cam_new     = cn;
        t.cam_x       = cx;
        t.cam_y       = cy;
        t.cam_heading = ch;
        return t;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
        endcase
    endfunction

    // Headings cluster around the unwrap threshold and around +-pi.
    function automatic int rand_angle();
        longint v;
        longint jit;
        jit = longint'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0:       v = longint'($signed($urandom));
            1:       v = ANG_3Q + jit;
            2:       v = ANG_PI + jit;
            3:       v = 0;
            default: v = longint'($urandom_range(0, 32'(2 * (ANG_PI + 2000))))
                         - (ANG_PI + 2000);
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return 32'(v);
    endfunction

    function automatic wpf_pkg::tick_t rand_tick();
        return make_tick($urandom_range(0, 99) < 70, rand_coord(), rand_coord(), rand_angle(),
                         $urandom_range(0, 99) < 30, rand_coord(), rand_coord(), rand_angle());
    endfunction

    function automatic int rand_start_heading();
        return int'($urandom_range(0, 32'(2 * ANG_PI))) - int'(ANG_PI);
    endfunction

    task automatic test_reset_values();
        reg_readback(wpf_pkg::REG_START_X);
        reg_readback(wpf_pkg::REG_START_Y);
        reg_readback(wpf_pkg::REG_START_H);
        reg_readback(wpf_pkg::REG_PERIOD);
    endtask

    // Every warm-up tick repeats the start pose, whatever it carries.
    task automatic test_warmup();
        wpf_pkg::tick_t t;
        for (int i = 0; i < WARMUP_LEN; i++)
        begin
            t         = rand_tick();
            t.odo_new = 1'b1;
            t.cam_new = i[0];
            send_tick(t);
        end
    endtask

    task automatic test_fusion_cases();
        settle();
        reg_write(wpf_pkg::REG_PERIOD, 32'd1);
        send_tick(make_tick(1, S32_MAX, S32_MAX, 0, 1, S32_MAX, S32_MAX, 0));
        send_tick(make_tick(1, S32_MIN, S32_MIN, 0, 1, S32_MIN, S32_MIN, 0));
        send_tick(make_tick(1, S32_MAX, S32_MIN, 1000, 1, S32_MIN, S32_MAX, 2000));
        // Odometry below the camera across the seam, then the camera below.
        send_tick(make_tick(1, 100, 200, -200000, 1, 300, 400, int'(ANG_3Q + 1)));
        send_tick(make_tick(1, -100, -200, 200000, 1, 50, 60, int'(-(ANG_3Q + 1))));
        // Exactly at the threshold nothing is unwrapped.
        send_tick(make_tick(1, 0, 0, -1000, 1, 0, 0, int'(ANG_3Q)));
        send_tick(make_tick(1, 0, 0, 1000, 1, 0, 0, int'(-ANG_3Q)));
        // A zero heading has no sign.
        send_tick(make_tick(1, 0, 0, 0, 1, 0, 0, int'(ANG_PI)));
        send_tick(make_tick(1, 5, 5, int'(-ANG_PI), 1, 0, 0, 0));
        send_tick(make_tick(0, -1, -1, -1, 1, 65536, -65536, int'(-ANG_PI)));
        send_tick(make_tick(1, 7, 8, int'(ANG_PI + 1), 0, -1, -1, -1));
        send_tick(make_tick(1, 7, 8, int'(-ANG_PI - 1), 0, -1, -1, -1));
        send_tick(make_tick(1, 7, 8, int'(ANG_PI), 0, -1, -1, -1));
        send_tick(make_tick(1, 7, 8, int'(-ANG_PI), 0, -1, -1, -1));
        send_tick(make_tick(1, S32_MIN, S32_MAX, S32_MAX, 0, 0, 0, 0));
        send_tick(make_tick(1, S32_MAX, S32_MIN, S32_MIN, 0, 0, 0, 0));
        send_tick(make_tick(0, -1, -1, -1, 0, -1, -1, -1));
        send_tick(make_tick(1, 1, 1, 500000, 1, 2, 2, S32_MIN));
        send_tick(make_tick(1, 1, 1, S32_MIN, 1, 2, 2, S32_MAX));
    endtask

    // Period 255 leaves the idle count high; period 128 then sees no multiple
    // before the 8-bit counter rolls over to zero. Period 0 behaves as 1.
    task automatic test_idle_periods();
        wpf_pkg::tick_t t;
        settle();
        reg_write(wpf_pkg::REG_PERIOD, 32'd255);
        for (int i = 0; i < 150; i++)
        begin
            t         = rand_tick();
            t.cam_new = 1'b0;
            send_tick(t);
        end
        settle();
        reg_write(wpf_pkg::REG_PERIOD, 32'd128);
        for (int i = 0; i < 106; i++)
        begin
            t         = rand_tick();
            t.cam_new = 1'b0;
            send_tick(t);
        end
        settle();
        reg_write(wpf_pkg::REG_PERIOD, 32'd0);
        for (int i = 0; i < 12; i++)
        begin
            t         = rand_tick();
            t.cam_new = 1'b0;
            send_tick(t);
        end
    endtask

    task automatic test_start_pose();
        settle();
        reg_write(wpf_pkg::REG_START_X, S32_MIN);
        reg_write(wpf_pkg::REG_START_Y, S32_MAX);
        reg_write(wpf_pkg::REG_START_H, 32'(-ANG_PI));
        reg_write(wpf_pkg::REG_PERIOD, 32'd3);
        test_warmup();
        send_tick(make_tick(0, 0, 0, 0, 1, 1000, -1000, int'(ANG_PI)));
        for (int i = 0; i < 6; i++)
        begin
            send_tick(rand_tick());
        end
        settle();
        reg_write(wpf_pkg::REG_START_H, 32'(ANG_PI));
        reg_write(wpf_pkg::REG_START_X, S32_MAX);
        reg_write(wpf_pkg::REG_START_Y, S32_MIN);
        test_warmup();
        send_tick(make_tick(0, 0, 0, 0, 1, -1000, 1000, int'(-ANG_PI)));
        for (int i = 0; i < 6; i++)
        begin
            send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        end
    endtask

    // A random start pose is loaded once; each phase then sets its own period.
    task automatic test_random();
        int period;
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:       period = 4;
                1:       period = 1;
                2:       period = $urandom_range(1, 16);
                default: period = 255;
            endcase
            no_gaps = (phase == 1);
            if (phase == 0)
            begin
                reg_write(wpf_pkg::REG_START_X, rand_coord());
                reg_write(wpf_pkg::REG_START_Y, rand_coord());
                reg_write(wpf_pkg::REG_START_H, rand_start_heading());
            end
            reg_write(wpf_pkg::REG_PERIOD, period);
            if (phase == 0)
            begin
                test_warmup();
            end
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                send_tick(rand_tick());
            end
        end
        no_gaps = 1'b0;
    endtask

    // Pose receiver: random stalls ahead of each transfer, then the check.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                pose_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pose_ready <= 1'b1;
            do @(posedge clk); while (!pose_valid);
            check_pose(pose);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((tick_valid && tick_ready) || (pose_valid && pose_ready) || (psel && penable))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        idle_run = 8'd0;
        reload_start_pose();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_warmup();
        test_fusion_cases();
        test_idle_periods();
        test_start_pose();
        test_random();
        settle();

        $display("Sent %0d ticks; checked %0d fused and %0d odometry poses, %0d seam unwraps.",
                 ticks_sent, fused_seen, passed_seen, unwrap_hits);
        $display("Start pose extremes and output periods 0, 1, 128, 255 and random were swept.");
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
